@@ design/vconv_pkg.sv @@
// vconv_pkg: shared constants, types and command codes for the 5x5 valid convolution
// used by vconv_mac, valid_conv2d_line_buffer and its bench; depends on nothing
package vconv_pkg;

    localparam int IMAGE_ROWS  = 32;
    localparam int IMAGE_COLS  = 32;
    localparam int KERNEL_SIZE = 5;
    localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;

    localparam int PIX_W    = 16;
    localparam int WIDX_W   = 5;
    localparam int OUT_RC_W = 5;
    localparam int SUM_W    = 40;
    localparam int PROD_W   = 2 * PIX_W;
    localparam int ROWSUM_W = PROD_W + $clog2(KERNEL_SIZE);

    localparam int ROW_W  = $clog2(IMAGE_ROWS);
    localparam int COL_W  = $clog2(IMAGE_COLS);
    localparam int LINE_W = (KERNEL_SIZE - 1) * PIX_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    typedef logic signed [PIX_W-1:0] t_pix;
    typedef t_pix [KERNEL_TAPS-1:0] t_taps;

    typedef struct packed {
        logic [OUT_RC_W-1:0] row;
        logic [OUT_RC_W-1:0] col;
        logic                last;
    } t_meta;

endpackage

@@ design/vconv_ram.sv @@
// vconv_ram: generic single-clock ram, one write port and one registered read port
// standalone, no package dependency
module vconv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/vconv_mac.sv @@
// vconv_mac: pipelined multiply and adder tree, products then row sums then total
// depends on vconv_pkg for widths and the window, weight and tag types
module vconv_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  vconv_pkg::t_meta               i_meta,
    input  vconv_pkg::t_taps               i_win,
    input  vconv_pkg::t_taps               i_wgt,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [vconv_pkg::SUM_W-1:0] o_sum,
    output vconv_pkg::t_meta               o_meta
);

    logic r_v3, r_v4, r_vo;
    logic en3, en4, en_out;

    logic signed [vconv_pkg::PROD_W-1:0]   r_prod [vconv_pkg::KERNEL_TAPS];
    logic signed [vconv_pkg::ROWSUM_W-1:0] r_rsum [vconv_pkg::KERNEL_SIZE];
    logic signed [vconv_pkg::ROWSUM_W-1:0] n_rsum [vconv_pkg::KERNEL_SIZE];
    logic signed [vconv_pkg::SUM_W-1:0]    r_sum, n_sum;
    vconv_pkg::t_meta r_meta3, r_meta4, r_meta_o;

    assign en_out  = !r_vo || i_ready;
    assign en4     = !r_v4 || en_out;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;

    always_comb begin
        for (int kr = 0; kr < vconv_pkg::KERNEL_SIZE; kr++) begin
            n_rsum[kr] = '0;
            for (int kc = 0; kc < vconv_pkg::KERNEL_SIZE; kc++) begin
                n_rsum[kr] = n_rsum[kr] +
                    vconv_pkg::ROWSUM_W'(r_prod[kr * vconv_pkg::KERNEL_SIZE + kc]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int kr = 0; kr < vconv_pkg::KERNEL_SIZE; kr++) begin
            n_sum = n_sum + vconv_pkg::SUM_W'(r_rsum[kr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en_out) begin
                r_vo <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_meta3 <= i_meta;
            for (int i = 0; i < vconv_pkg::KERNEL_TAPS; i++) begin
                r_prod[i] <= $signed(i_win[i]) * $signed(i_wgt[i]);
            end
        end
        if (en4) begin
            r_meta4 <= r_meta3;
            r_rsum  <= n_rsum;
        end
        if (en_out) begin
            r_meta_o <= r_meta4;
            r_sum    <= n_sum;
        end
    end

    assign o_valid = r_vo;
    assign o_sum   = r_sum;
    assign o_meta  = r_meta_o;

endmodule

@@ design/valid_conv2d_line_buffer.sv @@
// valid_conv2d_line_buffer: 5x5 valid convolution over a raster pixel stream
// depends on vconv_pkg, vconv_ram (line memory) and vconv_mac (multiply and sum)
// o_m_axis_tvalid follows an accepted pixel through stages 1, 2 and the mac's registers;
// throughput: one transaction per cycle while i_m_axis_tready allows, pixels and weight loads
// alike, set by the line memory's single read and write per column and the 5-stage pipeline
// reset clears position counters, weights and pipeline valid bits; line memory is not cleared
module valid_conv2d_line_buffer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [vconv_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,  // weight_index, value
    input  logic                                i_s_axis_tuser,  // command
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [vconv_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,  // out_value, out_row, out_col
    output logic                                o_m_axis_tlast
);

    logic [vconv_pkg::WIDX_W-1:0] in_widx;
    vconv_pkg::t_pix              in_val;
    logic                         accept, en1, en2, mac_ready;
    logic                         col_last, row_last, in_full, in_keep;

    logic [vconv_pkg::ROW_W-1:0] r_row, d_row;
    logic [vconv_pkg::COL_W-1:0] r_col, d_col;

    logic                         r_v1, r_k1, r_keep1;
    vconv_pkg::t_pix              r_val1;
    logic [vconv_pkg::COL_W-1:0]  r_col1;
    logic [vconv_pkg::WIDX_W-1:0] r_widx1;
    vconv_pkg::t_meta             r_meta1, in_meta;

    logic                         r_v2, r_w2;
    vconv_pkg::t_pix              r_val2;
    logic [vconv_pkg::WIDX_W-1:0] r_widx2;
    vconv_pkg::t_meta             r_meta2;

    vconv_pkg::t_taps r_win, r_wgt;
    vconv_pkg::t_pix  col_new [vconv_pkg::KERNEL_SIZE];

    logic                         ram_we, ram_re;
    logic [vconv_pkg::LINE_W-1:0] ram_rdata, ram_wdata;

    logic                               mac_valid;
    logic signed [vconv_pkg::SUM_W-1:0] mac_sum;
    vconv_pkg::t_meta                   mac_meta;

    assign in_widx = i_s_axis_tdata[vconv_pkg::WIDX_W-1:0];
    assign in_val  = i_s_axis_tdata[vconv_pkg::WIDX_W +: vconv_pkg::PIX_W];

    // pipeline handshake, weights in stage 2 always retire
    assign en2             = !r_v2 || r_w2 || mac_ready;
    assign en1             = !r_v1 || en2;
    assign o_s_axis_tready = en1;
    assign accept          = i_s_axis_tvalid && en1;

    // raster position and output tag of the incoming pixel
    assign col_last = r_col == vconv_pkg::COL_W'(vconv_pkg::IMAGE_COLS - 1);
    assign row_last = r_row == vconv_pkg::ROW_W'(vconv_pkg::IMAGE_ROWS - 1);
    assign in_full  = 32'(r_row) >= vconv_pkg::KERNEL_SIZE - 1 &&
                      32'(r_col) >= vconv_pkg::KERNEL_SIZE - 1;
    assign d_row    = r_row - vconv_pkg::ROW_W'(vconv_pkg::KERNEL_SIZE - 1);
    assign d_col    = r_col - vconv_pkg::COL_W'(vconv_pkg::KERNEL_SIZE - 1);
    assign in_keep  = (i_s_axis_tuser == vconv_pkg::CMD_PIXEL) ? in_full
                    : 32'(in_widx) < vconv_pkg::KERNEL_TAPS;

    always_comb begin
        in_meta.row  = vconv_pkg::OUT_RC_W'(d_row);
        in_meta.col  = vconv_pkg::OUT_RC_W'(d_col);
        in_meta.last = row_last && col_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept && i_s_axis_tuser == vconv_pkg::CMD_PIXEL) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // line memory: one entry per column holds the previous rows
    assign ram_re = accept && i_s_axis_tuser == vconv_pkg::CMD_PIXEL;
    assign ram_we = r_v1 && r_k1 && en2;

    always_comb begin
        for (int j = 0; j < vconv_pkg::KERNEL_SIZE - 1; j++) begin
            col_new[j] = ram_rdata[j * vconv_pkg::PIX_W +: vconv_pkg::PIX_W];
        end
        col_new[vconv_pkg::KERNEL_SIZE - 1] = r_val1;
        for (int j = 0; j < vconv_pkg::KERNEL_SIZE - 1; j++) begin
            ram_wdata[j * vconv_pkg::PIX_W +: vconv_pkg::PIX_W] = col_new[j + 1];
        end
    end

    vconv_ram #(
        .WIDTH (vconv_pkg::LINE_W),
        .DEPTH (vconv_pkg::IMAGE_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col1),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // stage valid bits and kernel weights
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_wgt <= '0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1 && r_keep1;
            end
            if (r_v2 && r_w2) begin
                for (int i = 0; i < vconv_pkg::KERNEL_TAPS; i++) begin
                    if (32'(r_widx2) == i) begin
                        r_wgt[i] <= r_val2;
                    end
                end
            end
        end
    end

    // stage payloads and sliding window
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_k1    <= i_s_axis_tuser == vconv_pkg::CMD_PIXEL;
            r_keep1 <= in_keep;
            r_val1  <= in_val;
            r_col1  <= r_col;
            r_widx1 <= in_widx;
            r_meta1 <= in_meta;
        end
        if (en2) begin
            r_w2    <= !r_k1;
            r_val2  <= r_val1;
            r_widx2 <= r_widx1;
            r_meta2 <= r_meta1;
        end
        if (ram_we) begin
            for (int kr = 0; kr < vconv_pkg::KERNEL_SIZE; kr++) begin
                for (int kc = 0; kc < vconv_pkg::KERNEL_SIZE - 1; kc++) begin
                    r_win[kr * vconv_pkg::KERNEL_SIZE + kc] <=
                        r_win[kr * vconv_pkg::KERNEL_SIZE + kc + 1];
                end
                r_win[kr * vconv_pkg::KERNEL_SIZE + vconv_pkg::KERNEL_SIZE - 1] <=
                    col_new[kr];
            end
        end
    end

    assign mac_valid = r_v2 && !r_w2;

    vconv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mac_valid),
        .o_ready (mac_ready),
        .i_meta  (r_meta2),
        .i_win   (r_win),
        .i_wgt   (r_wgt),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_sum   (mac_sum),
        .o_meta  (mac_meta)
    );

    assign o_m_axis_tdata = {6'b0, mac_meta.col, mac_meta.row, mac_sum};
    assign o_m_axis_tlast = mac_meta.last;

    // line memory is never read and written at one column in the same cycle
    a_ram_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && r_col1 == r_col))
        else $error("line memory read and write collide");

    // the last result of a frame carries the final output position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
        (32'(mac_meta.row) == vconv_pkg::IMAGE_ROWS - vconv_pkg::KERNEL_SIZE &&
         32'(mac_meta.col) == vconv_pkg::IMAGE_COLS - vconv_pkg::KERNEL_SIZE))
        else $error("frame end tag at wrong position");

    // raster counters stay inside the image
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < vconv_pkg::IMAGE_COLS && 32'(r_row) < vconv_pkg::IMAGE_ROWS)
        else $error("raster position out of range");

    // a weight held in stage 2 is written and retired at the following edge
    a_wgt_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_w2) |=> !(r_v2 && r_w2 && $stable(r_widx2) && $stable(r_val2)
                             && !$past(r_v1)))
        else $error("weight entry stuck in stage 2");

endmodule
